@@ hdl/bit_tree_range_decoder_core_defines.svh @@
// assertion macros for the bit tree range decoder checker
`ifndef BIT_TREE_RANGE_DECODER_CORE_DEFINES_SVH
`define BIT_TREE_RANGE_DECODER_CORE_DEFINES_SVH

// same-cycle implication, sampled on clock, off during reset
`define BTRD_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define BTRD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/btrd_pkg.sv @@
// shared types and constants of the bit tree range decoder
`default_nettype none

package btrd_pkg;

   localparam int PROB_W      = 15;
   localparam int PROB_BITS   = 15;
   localparam int TABLE_DEPTH = 256;
   localparam int NODE_W      = 9;
   localparam int WIN_BYTES   = 16;
   localparam int USED_W      = 5;

   localparam logic FUNC_LOAD   = 1'b0;
   localparam logic FUNC_DECODE = 1'b1;

   localparam logic [31:0] SPAN_FLOOR = 32'h0100_0000;

   typedef struct packed {
      logic start;
      logic wr;
      logic mul;
      logic upd;
      logic out_load;
   } btrd_cmd_type;

endpackage

`default_nettype wire

@@ hdl/btrd_ctrl.sv @@
// controller state machine of the bit tree range decoder
`default_nettype none

module btrd_ctrl #(
   parameter int TREE_LEVELS = 8
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  req_func,
   output logic                       req_stall,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output btrd_pkg::btrd_cmd_type     cmd
);
   import btrd_pkg::*;

   localparam int LVL_W = (TREE_LEVELS > 1) ? $clog2(TREE_LEVELS) : 1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_UPD,
      ST_DONE
   } state_type;

   state_type        state_ff, state_in;
   logic [LVL_W-1:0] level_ff, level_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             last_level;
   logic             out_free;

   assign last_level = (level_ff == LVL_W'(TREE_LEVELS - 1));
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      level_in     = level_ff;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_func == FUNC_DECODE) begin
                  cmd.start = 1'b1;
                  level_in  = '0;
                  state_in  = ST_MUL;
               end else begin
                  cmd.wr = 1'b1;
               end
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_UPD;
         end
         ST_UPD: begin
            cmd.upd = 1'b1;
            if (last_level) begin
               state_in = ST_DONE;
            end else begin
               level_in = level_ff + LVL_W'(1);
               state_in = ST_MUL;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         level_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         level_ff     <= level_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

@@ hdl/btrd_dpath.sv @@
// datapath of the bit tree range decoder: table, multiplier, level update
`default_nettype none

module btrd_dpath (
   input  wire logic                  clock,
   input  wire btrd_pkg::btrd_cmd_type cmd,
   input  wire logic [7:0]            req_prob_index,
   input  wire logic [14:0]           req_prob_value,
   input  wire logic [31:0]           req_start_code,
   input  wire logic [31:0]           req_start_span,
   input  wire logic [63:0]           req_stream_low,
   input  wire logic [63:0]           req_stream_high,
   output logic [7:0]                 rsp_symbol,
   output logic [4:0]                 rsp_bytes_used,
   output logic [31:0]                rsp_end_code,
   output logic [31:0]                rsp_end_span
);
   import btrd_pkg::*;

   localparam int HI_W  = 32 - PROB_BITS;
   localparam int MUL_W = HI_W + PROB_W;

   logic [PROB_W-1:0] prob_mem [TABLE_DEPTH];

   logic [PROB_W-1:0] prob_ff;
   logic [31:0]       split_ff, split_in;
   logic [31:0]       code_ff, code_in;
   logic [31:0]       span_ff, span_in;
   logic [NODE_W-1:0] node_ff, node_in;
   logic [USED_W-1:0] used_ff, used_in;
   logic [63:0]       lo_ff, hi_ff;
   logic [7:0]        symbol_ff;
   logic [USED_W-1:0] bytes_used_ff;
   logic [31:0]       end_code_ff, end_span_ff;

   logic [MUL_W-1:0]  prod;
   logic              bit_dec;
   logic [31:0]       code_a, span_a;
   logic [1:0]        shifts;
   logic [7:0]        win_b [WIN_BYTES];
   logic [7:0]        byte_k [3];
   logic [USED_W-1:0] idx_k [3];
   logic [USED_W-1:0] used_sum;
   logic [31:0]       code_r, span_r;

   // split product
   assign prod     = MUL_W'(span_ff[31:PROB_BITS]) * MUL_W'(prob_ff);
   assign split_in = 32'(prod);

   always_comb begin
      for (int i = 0; i < WIN_BYTES / 2; i++) begin
         win_b[i]                 = lo_ff[8*i +: 8];
         win_b[i + WIN_BYTES / 2] = hi_ff[8*i +: 8];
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         idx_k[k] = used_ff + USED_W'(k);
         if (idx_k[k] < USED_W'(WIN_BYTES)) begin
            byte_k[k] = win_b[idx_k[k][3:0]];
         end else begin
            byte_k[k] = 8'h00;
         end
      end
   end

   // one tree level: bit decision then renormalization
   always_comb begin
      bit_dec = (code_ff >= split_ff);
      if (bit_dec) begin
         span_a = span_ff - split_ff;
         code_a = code_ff - split_ff;
      end else begin
         span_a = split_ff;
         code_a = code_ff;
      end
      if (span_a >= SPAN_FLOOR) begin
         shifts = 2'd0;
      end else if (span_a[23:16] != 8'h00) begin
         shifts = 2'd1;
      end else if (span_a[15:8] != 8'h00) begin
         shifts = 2'd2;
      end else begin
         shifts = 2'd3;
      end
      case (shifts)
         2'd0: begin
            code_r = code_a;
            span_r = span_a;
         end
         2'd1: begin
            code_r = {code_a[23:0], byte_k[0]};
            span_r = {span_a[23:0], 8'h00};
         end
         2'd2: begin
            code_r = {code_a[15:0], byte_k[0], byte_k[1]};
            span_r = {span_a[15:0], 16'h0000};
         end
         default: begin
            code_r = {code_a[7:0], byte_k[0], byte_k[1], byte_k[2]};
            span_r = {span_a[7:0], 24'h000000};
         end
      endcase
      used_sum = used_ff + USED_W'(shifts);
      if (used_sum > USED_W'(WIN_BYTES)) begin
         used_in = USED_W'(WIN_BYTES);
      end else begin
         used_in = used_sum;
      end
   end

   always_comb begin
      code_in = code_ff;
      span_in = span_ff;
      node_in = node_ff;
      if (cmd.start) begin
         code_in = req_start_code;
         span_in = req_start_span;
         node_in = NODE_W'(1);
      end else if (cmd.upd) begin
         code_in = code_r;
         span_in = span_r;
         node_in = {node_ff[NODE_W-2:0], bit_dec};
      end
   end

   // probability table, registered read of the next node
   always_ff @(posedge clock) begin
      if (cmd.wr) begin
         prob_mem[req_prob_index] <= req_prob_value;
      end
      prob_ff <= prob_mem[node_in[7:0]];
   end

   always_ff @(posedge clock) begin
      code_ff <= code_in;
      span_ff <= span_in;
      node_ff <= node_in;
      if (cmd.start) begin
         used_ff <= '0;
         lo_ff   <= req_stream_low;
         hi_ff   <= req_stream_high;
      end else if (cmd.upd) begin
         used_ff <= used_in;
      end
      if (cmd.mul) begin
         split_ff <= split_in;
      end
      if (cmd.out_load) begin
         symbol_ff     <= node_ff[7:0];
         bytes_used_ff <= used_ff;
         end_code_ff   <= code_ff;
         end_span_ff   <= span_ff;
      end
   end

   assign rsp_symbol     = symbol_ff;
   assign rsp_bytes_used = bytes_used_ff;
   assign rsp_end_code   = end_code_ff;
   assign rsp_end_span   = end_span_ff;

endmodule

`default_nettype wire

@@ hdl/bit_tree_range_decoder_core.sv @@
// top level of the bit tree range decoder
//
// req channel: one transfer per item, req_func selects a table load or a decode.
//   a load writes prob_value into table entry prob_index and yields no rsp.
//   a decode walks TREE_LEVELS tree levels from node 1 and yields one rsp.
// rsp channel: symbol, bytes_used, end_code and end_span of one decode.
// decode steps: each level passes through the shared multiplier step, then
//   the compare, subtract and byte shift step, with the next node's table
//   read overlapping the latter; a final step loads the output register
//   and rsp_valid.
// a decode holds off every further req until it has loaded the output
//   register; while idle, one load per cycle is taken. req_stall is high
//   while a decode is in flight, for loads as well; a load never raises it.
// a finished result sits in the output register; the next req is taken
//   while it waits. a rsp_stall that holds the register also holds the
//   decoder in its final step until the register frees up.
// reset clears the controller and rsp_valid; the probability table is not
//   cleared, every node read by a decode must be loaded first.
`default_nettype none

module bit_tree_range_decoder_core #(
   parameter int TREE_LEVELS = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_func,
   input  wire logic [7:0]  req_prob_index,
   input  wire logic [14:0] req_prob_value,
   input  wire logic [31:0] req_start_code,
   input  wire logic [31:0] req_start_span,
   input  wire logic [63:0] req_stream_low,
   input  wire logic [63:0] req_stream_high,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_symbol,
   output logic [4:0]       rsp_bytes_used,
   output logic [31:0]      rsp_end_code,
   output logic [31:0]      rsp_end_span
);
   import btrd_pkg::*;

   btrd_cmd_type cmd;

   btrd_ctrl #(
      .TREE_LEVELS (TREE_LEVELS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   btrd_dpath u_dpath (
      .clock           (clock),
      .cmd             (cmd),
      .req_prob_index  (req_prob_index),
      .req_prob_value  (req_prob_value),
      .req_start_code  (req_start_code),
      .req_start_span  (req_start_span),
      .req_stream_low  (req_stream_low),
      .req_stream_high (req_stream_high),
      .rsp_symbol      (rsp_symbol),
      .rsp_bytes_used  (rsp_bytes_used),
      .rsp_end_code    (rsp_end_code),
      .rsp_end_span    (rsp_end_span)
   );

endmodule

`default_nettype wire

@@ hdl/btrd_checker.sv @@
// port checker of the bit tree range decoder and its bind
`default_nettype none
`include "bit_tree_range_decoder_core_defines.svh"

module btrd_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_stall,
   input wire logic       req_func,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [4:0] rsp_bytes_used
);
   import btrd_pkg::*;

   `BTRD_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid, "rsp dropped while stalled")
   `BTRD_ASSERT_NOW(a_used_max, rsp_valid, rsp_bytes_used <= 5'd16, "bytes_used above 16")
   `BTRD_ASSERT_NEXT(a_decode_busy, req_valid && !req_stall && req_func == FUNC_DECODE, req_stall, "no stall after decode transfer")
   `BTRD_ASSERT_NEXT(a_load_free, req_valid && !req_stall && req_func == FUNC_LOAD, !req_stall, "stall after load transfer")

endmodule

bind bit_tree_range_decoder_core btrd_checker u_btrd_checker (.*);

`default_nettype wire

@@ verif/bit_tree_range_decoder_core_tb.sv @@
// testbench for the bit tree range decoder core: directed and random traffic
`timescale 1ns / 100ps

module bit_tree_range_decoder_core_tb;
   import btrd_pkg::*;

   localparam int TREE_DEPTH   = 8;
   localparam int MAX_SHIFTS   = 3;
   localparam int RANDOM_ITEMS = 120;
   localparam int IDLE_PCT     = 34;
   localparam int CYCLE_LIMIT  = 200000;

   typedef struct {
      logic [7:0]  symbol;
      logic [4:0]  bytes_used;
      logic [31:0] end_code;
      logic [31:0] end_span;
   } symbol_rec_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_func = FUNC_LOAD;
   logic [7:0]  req_prob_index = '0;
   logic [14:0] req_prob_value = '0;
   logic [31:0] req_start_code = '0;
   logic [31:0] req_start_span = '0;
   logic [63:0] req_stream_low = '0;
   logic [63:0] req_stream_high = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_symbol;
   logic [4:0]  rsp_bytes_used;
   logic [31:0] rsp_end_code;
   logic [31:0] rsp_end_span;

   logic [14:0]    prob_copy [TABLE_DEPTH];
   logic           prob_loaded [TABLE_DEPTH];
   symbol_rec_type pending_symbols [$];
   logic           quiet = 1'b0;
   int             error_count = 0;
   int             load_count = 0;
   int             decode_count = 0;
   int             checked_count = 0;
   int             cycle_count = 0;

   bit_tree_range_decoder_core #(.TREE_LEVELS(TREE_DEPTH)) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_func(req_func),
      .req_prob_index(req_prob_index),
      .req_prob_value(req_prob_value),
      .req_start_code(req_start_code),
      .req_start_span(req_start_span),
      .req_stream_low(req_stream_low),
      .req_stream_high(req_stream_high),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_symbol(rsp_symbol),
      .rsp_bytes_used(rsp_bytes_used),
      .rsp_end_code(rsp_end_code),
      .rsp_end_span(rsp_end_span)
   );

   always #10 clock = ~clock;

   // returns 0 when the walk would touch a node that was never loaded
   function automatic logic walk_bit_tree(input logic [31:0] code_in, input logic [31:0] span_in,
         input logic [63:0] lo, input logic [63:0] hi, output symbol_rec_type res);
      logic [31:0]  code;
      logic [31:0]  span;
      logic [31:0]  split;
      logic [31:0]  prob;
      logic [8:0]   node;
      logic [4:0]   used;
      logic [127:0] window;
      logic [7:0]   next_byte;
      logic         bit_one;
      logic         loaded;
      code = code_in;
      span = span_in;
      node = 9'd1;
      used = '0;
      window = {hi, lo};
      loaded = 1'b1;
      for (int lvl = 0; lvl < TREE_DEPTH; lvl++) begin
         loaded = loaded & prob_loaded[node[7:0]];
         prob = {17'd0, prob_copy[node[7:0]]};
         split = (span >> PROB_BITS) * prob;
         bit_one = (code >= split);
         if (bit_one) begin
            span = span - split;
            code = code - split;
         end else begin
            span = split;
         end
         for (int n = 0; n < MAX_SHIFTS && span < SPAN_FLOOR; n++) begin
            next_byte = (used < WIN_BYTES) ? window[8 * used +: 8] : 8'h00;
            code = {code[23:0], next_byte};
            span = span << 8;
            if (used < WIN_BYTES) used++;
         end
         node = {node[7:0], bit_one};
      end
      res.symbol = node[7:0];
      res.bytes_used = used;
      res.end_code = code;
      res.end_span = span;
      return loaded;
   endfunction

   function automatic logic [14:0] random_prob();
      case ($urandom_range(15, 0))
         0: return 15'd0;
         1: return 15'h7FFF;
         2: return 15'd1;
         default: return 15'($urandom_range(32767, 1));
      endcase
   endfunction

   task automatic send_item(input logic func, input logic [7:0] idx, input logic [14:0] val,
         input logic [31:0] code, input logic [31:0] span, input logic [63:0] lo,
         input logic [63:0] hi);
      symbol_rec_type want;
      logic           safe;
      safe = 1'b1;
      if (func == FUNC_DECODE) safe = walk_bit_tree(code, span, lo, hi, want);
      if (!safe) return;
      while (!quiet && $urandom_range(99, 0) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= func;
      req_prob_index <= idx;
      req_prob_value <= val;
      req_start_code <= code;
      req_start_span <= span;
      req_stream_low <= lo;
      req_stream_high <= hi;
      do @(posedge clock); while (req_stall);
      if (func == FUNC_LOAD) begin
         prob_copy[idx] = val;
         prob_loaded[idx] = 1'b1;
         load_count++;
      end else begin
         pending_symbols.push_back(want);
         decode_count++;
      end
   endtask

   task automatic load_prob(input logic [7:0] idx, input logic [14:0] val);
      send_item(FUNC_LOAD, idx, val, $urandom, $urandom, {$urandom, $urandom},
         {$urandom, $urandom});
   endtask

   task automatic decode_item(input logic [31:0] code, input logic [31:0] span,
         input logic [63:0] lo, input logic [63:0] hi);
      send_item(FUNC_DECODE, 8'($urandom), 15'($urandom), code, span, lo, hi);
   endtask

   task automatic test_table_loads();
      load_prob(8'd0, 15'h7FFF);
      load_prob(8'd255, 15'd0);
      for (int k = 0; k < TREE_DEPTH; k++) load_prob(8'(1 << k), 15'd1);
   endtask

   // all-zero path, zero stream, many shifts
   task automatic test_window_exhaust();
      decode_item(32'd0, SPAN_FLOOR, 64'd0, 64'd0);
      decode_item(32'd0, 32'hFFFF_FFFF, 64'd0, 64'd0);
   endtask

   // all-one path with zero probabilities, span zero and small start span
   task automatic test_dead_span();
      for (int k = 0; k < TREE_DEPTH; k++) load_prob(8'((2 << k) - 1), 15'd0);
      decode_item(32'hFFFF_FFFF, 32'd0, '1, '1);
      decode_item($urandom, 32'h0000_1234, {$urandom, $urandom}, {$urandom, $urandom});
      decode_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, {$urandom, $urandom}, {$urandom, $urandom});
   endtask

   task automatic test_prob_extremes();
      load_prob(8'd1, 15'h7FFF);
      decode_item(32'd0, 32'hFFFF_FFFF, 64'd0, 64'd0);
      decode_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, {$urandom, $urandom}, {$urandom, $urandom});
   endtask

   task automatic test_random_traffic();
      logic [31:0] span;
      logic [31:0] code;
      for (int i = 0; i < TABLE_DEPTH; i++) load_prob(8'(i), random_prob());
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         quiet <= (i >= 40 && i < 80);
         if ($urandom_range(99, 0) < 20) begin
            load_prob(8'($urandom_range(255, 0)), random_prob());
         end else begin
            if ($urandom_range(9, 0) == 0) span = $urandom_range(SPAN_FLOOR - 1, 0);
            else span = $urandom_range(32'hFFFF_FFFF, SPAN_FLOOR);
            if ($urandom_range(4, 0) != 0 && span != 0) code = $urandom_range(span - 1, 0);
            else code = $urandom;
            decode_item(code, span, {$urandom, $urandom}, {$urandom, $urandom});
         end
      end
      quiet <= 1'b0;
   endtask

   always @(posedge clock) begin : check_rsp
      symbol_rec_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_symbols.size() == 0) begin
            $error("unexpected rsp transfer: symbol %0h", rsp_symbol);
            error_count++;
         end else begin
            want = pending_symbols.pop_front();
            checked_count++;
            if (rsp_symbol !== want.symbol) begin
               $error("symbol: expected %0h, actual %0h", want.symbol, rsp_symbol);
               error_count++;
            end
            if (rsp_bytes_used !== want.bytes_used) begin
               $error("bytes_used: expected %0d, actual %0d", want.bytes_used, rsp_bytes_used);
               error_count++;
            end
            if (rsp_end_code !== want.end_code) begin
               $error("end_code: expected %0h, actual %0h", want.end_code, rsp_end_code);
               error_count++;
            end
            if (rsp_end_span !== want.end_span) begin
               $error("end_span: expected %0h, actual %0h", want.end_span, rsp_end_span);
               error_count++;
            end
         end
      end
      rsp_stall <= quiet ? 1'b0 : ($urandom_range(99, 0) < IDLE_PCT);
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout with %0d results outstanding", pending_symbols.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         prob_copy[i] = '0;
         prob_loaded[i] = 1'b0;
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_table_loads();
      test_window_exhaust();
      test_dead_span();
      test_prob_extremes();
      test_random_traffic();
      req_valid <= 1'b0;
      while (pending_symbols.size() != 0) @(posedge clock);
      repeat (2 * TREE_DEPTH + 8) @(posedge clock);
      $display("run covered %0d table loads and %0d decodes, %0d results compared",
         load_count, decode_count, checked_count);
      $display("including window exhaustion, dead and small spans, and random stalls");
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

@@ files.f @@
+incdir+hdl
hdl/btrd_pkg.sv
hdl/btrd_ctrl.sv
hdl/btrd_dpath.sv
hdl/bit_tree_range_decoder_core.sv
hdl/btrd_checker.sv
verif/bit_tree_range_decoder_core_tb.sv
